>>> hw/rtl/rws_pkg.sv
// rws_pkg: shared constants, word types and control structs for the
// roulette wheel selection block. No dependencies.
package rws_pkg;

   // sizing
   localparam int POP_MAX      = 256;
   localparam int FITNESS_BITS = 16;
   localparam int IDX_BITS     = $clog2(POP_MAX);
   localparam int SUM_BITS     = FITNESS_BITS + IDX_BITS;
   localparam int RAND_BITS    = 16;
   localparam int SIZE_BITS    = 9;
   localparam int PROD_BITS    = RAND_BITS + SUM_BITS;

   // command codes
   typedef enum logic {
      CMD_WRITE  = 1'b0,
      CMD_SELECT = 1'b1
   } cmd_type;

   // request word
   typedef struct packed {
      cmd_type     command;
      logic [7:0]  member_index;
      logic [15:0] member_fitness;
      logic [15:0] random_fraction;
   } req_word_type;

   // response word
   typedef struct packed {
      logic [7:0]  selected_index;
      logic [15:0] selected_fitness;
   } rsp_word_type;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SUM,
      ST_SUM_TAIL,
      ST_MUL,
      ST_SCAN
   } st_type;

   // sequencer to datapath controls
   typedef struct packed {
      logic capture;
      logic acc_clear;
      logic acc_add;
      logic load_target;
   } ctl_type;

   // datapath to sequencer status
   typedef struct packed {
      logic hit;
   } sts_type;

endpackage

>>> hw/rtl/roulette_wheel_selection.sv
// roulette_wheel_selection: top level of the fitness proportionate selector.
// Depends on rws_pkg, rws_ram, rws_accum and rws_ctrl.
//
// Usage: a request word is taken at a clock edge with start high and busy
// low. A write word (command CMD_WRITE) stores member_fitness at member_index
// and busy stays low; no response follows. A select word
// (CMD_SELECT) raises busy while the block sums the first n stored fitness
// values (one store read per cycle), forms the target (random * total) >> 16
// in the multiply state, then rescans from entry 0 until the running sum
// reaches the target. The response word appears on rsp_word for exactly one
// cycle with rsp_valid high; the receiver cannot hold it off.
// Here n is the clamped population size. Busy falls as the strobe rises,
// so the next word can be taken while the strobe is high; no word is taken
// while a select is in progress, and the single store read port serves both
// the sum and the scan passes.
// The population size register is written through csr_we and csr_wdata;
// the user must write it only while idle; the block does not enforce this.
// A size of 0 acts as 1 and one above 256 as 256.
// Reset returns the sequencer to idle and the size to 256; the fitness store
// is not cleared and must be written before it is selected from.
module roulette_wheel_selection
   import rws_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  req_word_type         req_word,
   output logic                 busy,
   output logic                 rsp_valid,
   output rsp_word_type         rsp_word,
   input  logic                 csr_we,
   input  logic [SIZE_BITS-1:0] csr_wdata
);

   ctl_type                 ctl;
   sts_type                 sts;
   logic [IDX_BITS-1:0]     rd_addr;
   logic [IDX_BITS-1:0]     rd_idx;
   logic [FITNESS_BITS-1:0] rd_data;
   logic                    done;
   logic                    wr_en;
   logic                    rsp_valid_ff;
   rsp_word_type            rsp_word_ff;

   // store write for write words inside the store
   assign wr_en = start && !busy && (req_word.command == CMD_WRITE)
                  && (32'(req_word.member_index) < POP_MAX);

   rws_ram #(
      .WIDTH (FITNESS_BITS),
      .DEPTH (POP_MAX)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (IDX_BITS'(req_word.member_index)),
      .wr_data (req_word.member_fitness[FITNESS_BITS-1:0]),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   rws_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .command   (req_word.command),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .sts       (sts),
      .busy      (busy),
      .ctl       (ctl),
      .rd_addr   (rd_addr),
      .rd_idx    (rd_idx),
      .done      (done)
   );

   rws_accum u_accum (
      .clock   (clock),
      .ctl     (ctl),
      .rand_in (req_word.random_fraction[RAND_BITS-1:0]),
      .rd_data (rd_data),
      .sts     (sts)
   );

   // response strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= done;
      end
   end

   // response word
   always_ff @(posedge clock) begin
      if (done) begin
         rsp_word_ff.selected_index   <= 8'(rd_idx);
         rsp_word_ff.selected_fitness <= 16'(rd_data);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // a response only ends a select that was in progress
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("response without a select in progress");

   // one select gives one response
   a_single_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("back to back response strobes");

   // a write word completes in its own cycle
   a_write_no_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_word.command == CMD_WRITE) |=> !busy)
      else $error("write word left the block busy");

   // a select word starts the sequencer
   a_select_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_word.command == CMD_SELECT) |=> (busy && !rsp_valid))
      else $error("select word did not start the sequencer");

endmodule

>>> hw/rtl/rws_ram.sv
// rws_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module rws_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/rws_accum.sv
// rws_accum: shared accumulator, target multiplier and compare.
// Depends on rws_pkg.
module rws_accum
   import rws_pkg::*;
(
   input  logic                    clock,
   input  ctl_type                 ctl,
   input  logic [RAND_BITS-1:0]    rand_in,
   input  logic [FITNESS_BITS-1:0] rd_data,
   output sts_type                 sts
);

   logic [RAND_BITS-1:0] rand_ff;
   logic [SUM_BITS-1:0]  acc_ff, acc_in;
   logic [SUM_BITS-1:0]  target_ff;
   logic [SUM_BITS-1:0]  sum_next;
   logic [PROD_BITS-1:0] product;

   // one adder serves both the total and the running sum
   assign sum_next = acc_ff + SUM_BITS'(rd_data);
   assign sts.hit  = (sum_next >= target_ff);

   // target = (random * total) >> 16
   assign product = PROD_BITS'(rand_ff) * PROD_BITS'(acc_ff);

   // accumulator next value
   always_comb begin
      acc_in = acc_ff;
      if (ctl.acc_clear) begin
         acc_in = '0;
      end else if (ctl.acc_add) begin
         acc_in = sum_next;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      if (ctl.capture) begin
         rand_ff <= rand_in;
      end
      if (ctl.load_target) begin
         target_ff <= product[PROD_BITS-1:RAND_BITS];
      end
   end

endmodule

>>> hw/rtl/rws_ctrl.sv
// rws_ctrl: sequencer for the sum, multiply and scan passes, store address
// counter and the population size register. Depends on rws_pkg.
module rws_ctrl
   import rws_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  cmd_type              command,
   input  logic                 csr_we,
   input  logic [SIZE_BITS-1:0] csr_wdata,
   input  sts_type              sts,
   output logic                 busy,
   output ctl_type              ctl,
   output logic [IDX_BITS-1:0]  rd_addr,
   output logic [IDX_BITS-1:0]  rd_idx,
   output logic                 done
);

   st_type               state_ff, state_in;
   logic [SIZE_BITS-1:0] size_ff;
   logic [IDX_BITS:0]    addr_ff, addr_in;
   logic [IDX_BITS-1:0]  last_ff, last_in;
   logic [IDX_BITS-1:0]  rd_idx_ff;
   logic                 rd_valid_ff;
   logic                 accept_sel;
   logic                 issue;

   assign busy       = (state_ff != ST_IDLE);
   assign accept_sel = start && !busy && (command == CMD_SELECT);

   // last index taking part, from the clamped population size
   always_comb begin
      if (size_ff == '0) begin
         last_in = '0;
      end else if (32'(size_ff) > POP_MAX) begin
         last_in = IDX_BITS'(POP_MAX - 1);
      end else begin
         last_in = IDX_BITS'(size_ff - SIZE_BITS'(1));
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept_sel) state_in = ST_SUM;
         end
         ST_SUM: begin
            if (addr_ff == {1'b0, last_ff}) state_in = ST_SUM_TAIL;
         end
         ST_SUM_TAIL: state_in = ST_MUL;
         ST_MUL:      state_in = ST_SCAN;
         ST_SCAN: begin
            if (done) state_in = ST_IDLE;
         end
         default:     state_in = ST_IDLE;
      endcase
   end

   // outputs and address counter
   always_comb begin
      issue           = ((state_ff == ST_SUM) || (state_ff == ST_SCAN))
                        && (addr_ff <= {1'b0, last_ff});
      ctl.capture     = accept_sel;
      ctl.acc_clear   = accept_sel || (state_ff == ST_MUL);
      ctl.load_target = (state_ff == ST_MUL);
      ctl.acc_add     = rd_valid_ff && ((state_ff == ST_SUM)
                        || (state_ff == ST_SUM_TAIL) || (state_ff == ST_SCAN));
      done            = (state_ff == ST_SCAN) && rd_valid_ff
                        && (sts.hit || (rd_idx_ff == last_ff));
      addr_in         = addr_ff;
      if (accept_sel || (state_ff == ST_MUL)) begin
         addr_in = '0;
      end else if (issue) begin
         addr_in = addr_ff + 1'b1;
      end
   end

   assign rd_addr = addr_ff[IDX_BITS-1:0];
   assign rd_idx  = rd_idx_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         size_ff     <= SIZE_BITS'(POP_MAX);
         addr_ff     <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         addr_ff     <= addr_in;
         rd_valid_ff <= issue;
         if (csr_we) begin
            size_ff <= csr_wdata;
         end
      end
   end

   // read tag and captured last index
   always_ff @(posedge clock) begin
      rd_idx_ff <= addr_ff[IDX_BITS-1:0];
      if (accept_sel) begin
         last_ff <= last_in;
      end
   end

endmodule

>>> test/tb.sv
// tb: self-checking bench for the roulette wheel selector top level.
// Depends on rws_pkg and roulette_wheel_selection; predicts every select word
// from its own copy of the fitness store and checks each response strobe.
module tb;
   import rws_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned RESET_CYCLES = 6;
   localparam int unsigned DRAIN_CYCLES = 2 * POP_MAX + 8;
   localparam int unsigned LIMIT_CYCLES = 5_000_000;
   localparam int unsigned NUM_PHASES   = 12;

   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 start     = 1'b0;
   req_word_type         req_word  = '0;
   logic                 busy;
   logic                 rsp_valid;
   rsp_word_type         rsp_word;
   logic                 csr_we    = 1'b0;
   logic [SIZE_BITS-1:0] csr_wdata = '0;

   // words waiting to be sent and selections waiting to come back
   req_word_type stim_words[$];
   rsp_word_type picks_due[$];
   rsp_word_type due_word;

   // own copy of the store and the size register
   logic [FITNESS_BITS-1:0] wheel_fit[POP_MAX];
   int unsigned             wheel_size = POP_MAX;

   int unsigned idle_pct    = 0;
   int unsigned errors      = 0;
   int unsigned cycle_count = 0;
   bit          word_taken  = 1'b0;

   // sizes written per phase, including zero and all ones
   int unsigned phase_sizes[NUM_PHASES] =
      '{256, 1, 0, 3, 17, 64, 511, 9, 300, 2, 128, 40};
   int unsigned idle_modes[3] = '{0, 78, 25};

   roulette_wheel_selection dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_word  (req_word),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // clamp a raw size register value to the entries taking part
   function automatic int unsigned wheel_span(input int unsigned raw);
      int unsigned n;
      n = raw;
      if (n == 0) n = 1;
      if (n > POP_MAX) n = POP_MAX;
      return n;
   endfunction

   // spin the wheel: first entry whose running sum reaches the target
   function automatic rsp_word_type pick_member(input logic [RAND_BITS-1:0] frac);
      int unsigned           n;
      int unsigned           i;
      int unsigned           pick;
      bit                    hit;
      logic [SUM_BITS-1:0]   total;
      logic [SUM_BITS-1:0]   target;
      logic [SUM_BITS-1:0]   acc;
      logic [PROD_BITS-1:0]  prod;
      rsp_word_type          res;
      n     = wheel_span(wheel_size);
      total = '0;
      for (i = 0; i < n; i++) total += wheel_fit[i];
      prod   = PROD_BITS'(frac) * PROD_BITS'(total);
      target = SUM_BITS'(prod >> RAND_BITS);
      acc  = '0;
      pick = n - 1;
      hit  = 1'b0;
      for (i = 0; i < n && !hit; i++) begin
         acc += wheel_fit[i];
         if (acc >= target) begin
            pick = i;
            hit  = 1'b1;
         end
      end
      res.selected_index   = pick[7:0];
      res.selected_fitness = wheel_fit[pick];
      return res;
   endfunction

   function automatic req_word_type make_word(input cmd_type c, input logic [7:0] idx,
                                              input logic [15:0] fit,
                                              input logic [15:0] frac);
      req_word_type w;
      w.command         = c;
      w.member_index    = idx;
      w.member_fitness  = fit;
      w.random_fraction = frac;
      return w;
   endfunction

   // fitness or fraction with the corners and small values favoured
   function automatic logic [15:0] skewed_value();
      logic [15:0] v;
      case ($urandom_range(0, 7))
         0: v = 16'h0000;
         1: v = 16'hFFFF;
         2: v = 16'($urandom_range(0, 15));
         default: v = 16'($urandom);
      endcase
      return v;
   endfunction

   // driver: present words at the falling edge, hold until taken
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (start && !word_taken) begin
         start <= 1'b1;
      end else if (stim_words.size() != 0 && $urandom_range(1, 100) > idle_pct) begin
         start    <= 1'b1;
         req_word <= stim_words.pop_front();
      end else begin
         start <= 1'b0;
      end
   end

   // monitor: check responses, then feed accepted words to the predictor
   always @(posedge clock) begin
      word_taken = 1'b0;
      if (reset) begin
         wheel_size = POP_MAX;
      end else begin
         if (rsp_valid) begin
            if (picks_due.size() == 0) begin
               $error("response with none expected: selected_index %0d", rsp_word.selected_index);
               errors++;
            end else begin
               due_word = picks_due.pop_front();
               if (rsp_word.selected_index !== due_word.selected_index) begin
                  $error("selected_index expected %0d actual %0d",
                         due_word.selected_index, rsp_word.selected_index);
                  errors++;
               end
               if (rsp_word.selected_fitness !== due_word.selected_fitness) begin
                  $error("selected_fitness expected 0x%04h actual 0x%04h",
                         due_word.selected_fitness, rsp_word.selected_fitness);
                  errors++;
               end
            end
         end
         if (start && !busy) begin
            word_taken = 1'b1;
            if (req_word.command == CMD_WRITE) begin
               wheel_fit[req_word.member_index] = req_word.member_fitness;
            end else begin
               picks_due.push_back(pick_member(req_word.random_fraction));
            end
         end
         if (csr_we) wheel_size = csr_wdata;
      end
   end

   // wait until every word is sent and every selection has come back
   task automatic wait_idle();
      while (stim_words.size() != 0 || start || picks_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // size register write while the block is quiet
   task automatic set_size(input int unsigned val);
      wait_idle();
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= SIZE_BITS'(val);
      @(negedge clock);
      csr_we    <= 1'b0;
      @(posedge clock);
   endtask

   // random mix of writes and selects for one size setting
   task automatic queue_random(input int unsigned raw_size, input int unsigned count);
      int unsigned n;
      int unsigned k;
      logic [7:0]  idx;
      for (k = 0; k < count; k++) begin
         n = wheel_span(raw_size);
         if ($urandom_range(0, 99) < 62) begin
            stim_words.push_back(make_word(CMD_SELECT, 8'($urandom), 16'($urandom),
                                           skewed_value()));
         end else begin
            if ($urandom_range(0, 1)) idx = 8'($urandom_range(0, n - 1));
            else idx = 8'($urandom);
            stim_words.push_back(make_word(CMD_WRITE, idx, skewed_value(), 16'($urandom)));
         end
      end
   endtask

   // stimulus sequence and final verdict
   initial begin
      int unsigned i;
      int unsigned p;
      int unsigned count;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // fill the whole store so no select ever reads an unwritten entry
      for (i = 0; i < POP_MAX; i++)
         stim_words.push_back(make_word(CMD_WRITE, 8'(i), 16'($urandom), 16'($urandom)));

      // directed: zero wheel, zero fraction, full fraction, corner entries
      set_size(4);
      for (i = 0; i < 4; i++)
         stim_words.push_back(make_word(CMD_WRITE, 8'(i), 16'h0000, 16'hFFFF));
      stim_words.push_back(make_word(CMD_SELECT, 8'h00, 16'h0000, 16'hFFFF));
      stim_words.push_back(make_word(CMD_SELECT, 8'hFF, 16'hFFFF, 16'h0000));
      stim_words.push_back(make_word(CMD_WRITE, 8'd2, 16'hFFFF, 16'h0000));
      stim_words.push_back(make_word(CMD_SELECT, 8'h00, 16'h0000, 16'h8000));
      stim_words.push_back(make_word(CMD_SELECT, 8'h00, 16'h0000, 16'h0000));
      stim_words.push_back(make_word(CMD_WRITE, 8'd0, 16'hFFFF, 16'h0000));
      stim_words.push_back(make_word(CMD_WRITE, 8'd3, 16'h0001, 16'h0000));
      stim_words.push_back(make_word(CMD_SELECT, 8'h00, 16'h0000, 16'hFFFF));
      stim_words.push_back(make_word(CMD_SELECT, 8'h00, 16'h0000, 16'h0001));
      stim_words.push_back(make_word(CMD_WRITE, 8'hFF, 16'hFFFF, 16'hFFFF));
      stim_words.push_back(make_word(CMD_WRITE, 8'd1, 16'h5555, 16'h0000));
      stim_words.push_back(make_word(CMD_SELECT, 8'hFF, 16'hFFFF, 16'hAAAA));
      stim_words.push_back(make_word(CMD_SELECT, 8'h00, 16'h0000, 16'hFFFE));

      // random phases over the size settings and idling modes
      for (p = 0; p < NUM_PHASES; p++) begin
         set_size(phase_sizes[p]);
         idle_pct = idle_modes[p % 3];
         count = (wheel_span(phase_sizes[p]) >= 128) ? 25 : 100;
         queue_random(phase_sizes[p], count);
      end

      wait_idle();
      if (errors == 0 && picks_due.size() == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

   // run limit
   initial begin
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb NOT OK");
      $finish;
   end

endmodule
